### rtl/sgc_pkg.sv
// Shared types and constants of the Sobol Gray-code point generator.
`default_nettype none

package sgc_pkg;

  // Field widths of the item and result transactions
  localparam int unsigned DIM_W = 6;
  localparam int unsigned BIT_W = 5;
  localparam int unsigned VAL_W = 30;

  // Call counter and column index widths
  localparam int unsigned CNT_W = 30;
  localparam int unsigned COL_W = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // Queue depths between front and back, and in front of the result port
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned OUT_DEPTH = 2;

  // Result status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_OVF = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_DIR = 2'd0,
    OP_LOAD_OFS = 2'd1,
    OP_RESTART  = 2'd2,
    OP_NEXT     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_RUN,
    ST_ERR,
    ST_SWEEP
  } bst_e;

  typedef struct packed {
    op_e              op;
    logic [DIM_W-1:0] dim;
    logic [BIT_W-1:0] bidx;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic [VAL_W-1:0] num;
    logic             last;
    logic             status;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [DIM_W-1:0] dims;
    logic [COL_W-1:0] cols;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/sgc_front.sv
// Front end: takes input transactions, drops out-of-range loads, forms commands.
`default_nettype none

module sgc_front #(
  parameter int unsigned MAX_DIMS = 40,
  parameter int unsigned MAX_BITS = 30
) (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [sgc_pkg::DIM_W-1:0]    dim_index_i,
  input  logic [sgc_pkg::BIT_W-1:0]    bit_index_i,
  input  logic [sgc_pkg::VAL_W-1:0]    load_value_i,
  input  sgc_pkg::q_stat_t             q_stat_i,
  output logic                         push_o,
  output sgc_pkg::cmd_t                cmd_o
);
  import sgc_pkg::*;

  logic dim_ok;
  logic bit_ok;
  logic keep;

  // Range-check the load addresses
  assign dim_ok = ((DIM_W + 1)'(dim_index_i) < (DIM_W + 1)'(MAX_DIMS));
  assign bit_ok = ((BIT_W + 1)'(bit_index_i) < (BIT_W + 1)'(MAX_BITS));

  // Classify: drop loads that point outside the stores
  always_comb begin
    case (op_e'(opcode_i))
      OP_LOAD_DIR: keep = dim_ok & bit_ok;
      OP_LOAD_OFS: keep = dim_ok;
      OP_RESTART:  keep = 1'b1;
      OP_NEXT:     keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  // Accept whenever the command queue has room
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i & ~q_stat_i.full & keep;

  assign cmd_o.op    = op_e'(opcode_i);
  assign cmd_o.dim   = dim_index_i;
  assign cmd_o.bidx  = bit_index_i;
  assign cmd_o.value = load_value_i;

endmodule

`default_nettype wire

### rtl/sgc_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none

module sgc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sgc_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output sgc_pkg::cmd_t    cmd_o,
  output sgc_pkg::q_stat_t stat_o
);
  import sgc_pkg::*;

  localparam int unsigned QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QC_W = $clog2(Q_DEPTH + 1);

  cmd_t            entry_q [Q_DEPTH];
  logic [QA_W-1:0] wp_q, wp_d;
  logic [QA_W-1:0] rp_q, rp_d;
  logic [QC_W-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;

  assign stat_o.full  = (cnt_q == QC_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = entry_q[rp_q];

  // Advance pointers and fill count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == QA_W'(Q_DEPTH - 1)) ? '0 : wp_q + QA_W'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == QA_W'(Q_DEPTH - 1)) ? '0 : rp_q + QA_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QC_W'(1);
      2'b01:   cnt_d = cnt_q - QC_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wp_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### rtl/sgc_back.sv
// Back end: stores, Gray-code step, restart copy and result buffer.
`default_nettype none

module sgc_back #(
  parameter int unsigned MAX_DIMS = 40,
  parameter int unsigned MAX_BITS = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgc_pkg::cfg_t    cfg_i,
  input  sgc_pkg::cmd_t    cmd_i,
  input  sgc_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sgc_pkg::res_t    res_o
);
  import sgc_pkg::*;

  localparam int unsigned DIR_DEPTH = MAX_DIMS * MAX_BITS;
  localparam int unsigned DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int unsigned LN_AW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned ND_W      = DIM_W + 1;
  localparam int unsigned OA_W      = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned OC_W      = $clog2(OUT_DEPTH + 1);

  // Stores
  logic [VAL_W-1:0]    dir_mem [DIR_DEPTH];
  logic [VAL_W-1:0]    ofs_mem [MAX_DIMS];
  logic [VAL_W-1:0]    ln_mem  [MAX_DIMS];
  logic [MAX_DIMS-1:0] ln_v_q;

  // Sequencer state
  bst_e              st_q, st_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              first_q, first_d;
  logic              xor_q, xor_d;
  logic [LN_AW-1:0]  d_q, d_d;
  logic [DIR_AW-1:0] dir_addr_q, dir_addr_d;
  logic [LN_AW-1:0]  sw_q, sw_d;

  // Read stage of a point
  logic              s1_v_q;
  logic [LN_AW-1:0]  s1_dim_q;
  logic              s1_last_q;
  logic              s1_xor_q;
  logic [VAL_W-1:0]  ln_rd_q;
  logic              lnv_rd_q;
  logic [VAL_W-1:0]  dir_rd_q;

  // Read stage of the restart copy
  logic              sw_wb_v_q;
  logic [LN_AW-1:0]  sw_wb_idx_q;
  logic [VAL_W-1:0]  ofs_rd_q;

  // Result buffer
  res_t              out_mem [OUT_DEPTH];
  logic [OA_W-1:0]   out_wp_q;
  logic [OA_W-1:0]   out_rp_q;
  logic [OC_W-1:0]   out_cnt_q;

  logic [ND_W-1:0]   nd;
  logic [COL_W-1:0]  eff_cols;
  logic [CNT_W:0]    cx;
  logic [CNT_W:0]    zero_hot;
  logic [COL_W-1:0]  tidx;
  logic [COL_W-1:0]  col;
  logic              out_pop;
  logic              out_push;
  logic              slot_ok;
  logic              run_issue;
  logic              sw_issue;
  logic              err_push;
  logic              dir_we;
  logic              ofs_we;
  logic [DIR_AW-1:0] dir_waddr;
  logic              run_wb;
  logic              ln_we;
  logic [LN_AW-1:0]  ln_waddr;
  logic [VAL_W-1:0]  ln_wdata;
  logic [VAL_W-1:0]  wb_num;
  logic              run_last;
  res_t              push_res;

  // Clamp the configured dimension and column counts
  always_comb begin
    if (cfg_i.dims == '0) begin
      nd = ND_W'(1);
    end else if (ND_W'(cfg_i.dims) > ND_W'(MAX_DIMS)) begin
      nd = ND_W'(MAX_DIMS);
    end else begin
      nd = ND_W'(cfg_i.dims);
    end
    eff_cols = (cfg_i.cols > COL_W'(MAX_BITS)) ? COL_W'(MAX_BITS) : cfg_i.cols;
  end

  // Column = 1 + trailing ones of the call counter: isolate lowest zero, encode it
  always_comb begin
    cx       = {1'b0, cnt_q};
    zero_hot = ~cx & (cx + (CNT_W + 1)'(1));
    tidx     = '0;
    for (int k = 0; k < int'(COL_W); k++) begin
      for (int i = 0; i <= int'(CNT_W); i++) begin
        if (((i >> k) & 1) != 0) begin
          tidx[k] = tidx[k] | zero_hot[i];
        end
      end
    end
    col = tidx + COL_W'(1);
  end

  // Result buffer room, counting a read still in flight
  assign out_valid_o = (out_cnt_q != '0);
  assign out_pop     = out_valid_o & ~out_stall_i;
  assign slot_ok     = (({1'b0, out_cnt_q} + (OC_W + 1)'(s1_v_q)) < (OC_W + 1)'(OUT_DEPTH))
                       | out_pop;
  assign res_o       = out_mem[out_rp_q];

  assign dir_waddr = DIR_AW'(int'(cmd_i.dim) * int'(MAX_BITS) + int'(cmd_i.bidx));
  assign run_last  = ((ND_W'(d_q) + ND_W'(1)) == nd);

  // Sequencer: next state and control
  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    xor_d      = xor_q;
    d_d        = d_q;
    dir_addr_d = dir_addr_q;
    sw_d       = sw_q;
    pop_o      = 1'b0;
    dir_we     = 1'b0;
    ofs_we     = 1'b0;
    run_issue  = 1'b0;
    sw_issue   = 1'b0;
    err_push   = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_LOAD_DIR: dir_we = 1'b1;
            OP_LOAD_OFS: ofs_we = 1'b1;
            OP_RESTART: begin
              cnt_d   = '0;
              first_d = 1'b1;
              sw_d    = '0;
              st_d    = ST_SWEEP;
            end
            OP_NEXT:     st_d = ST_CALC;
            default:     st_d = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        d_d = '0;
        if (first_q) begin
          first_d    = 1'b0;
          cnt_d      = '0;
          xor_d      = 1'b0;
          dir_addr_d = '0;
          st_d       = ST_RUN;
        end else if (col > eff_cols) begin
          st_d = ST_ERR;
        end else begin
          cnt_d      = cnt_q + CNT_W'(1);
          xor_d      = 1'b1;
          dir_addr_d = DIR_AW'(col - COL_W'(1));
          st_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_ok) begin
          run_issue  = 1'b1;
          d_d        = d_q + LN_AW'(1);
          dir_addr_d = dir_addr_q + DIR_AW'(MAX_BITS);
          if (run_last) begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_ok) begin
          err_push = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        sw_issue = 1'b1;
        sw_d     = sw_q + LN_AW'(1);
        if (sw_q == LN_AW'(MAX_DIMS - 1)) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Write back: XOR step of a point, or offset copy of a restart
  assign wb_num   = (lnv_rd_q ? ln_rd_q : '0) ^ (s1_xor_q ? dir_rd_q : '0);
  assign run_wb   = s1_v_q & s1_xor_q;
  assign ln_we    = run_wb | sw_wb_v_q;
  assign ln_waddr = run_wb ? s1_dim_q : sw_wb_idx_q;
  assign ln_wdata = run_wb ? wb_num : ofs_rd_q;

  // Form the result transaction
  assign out_push = s1_v_q | err_push;
  always_comb begin
    if (s1_v_q) begin
      push_res.dim    = DIM_W'(s1_dim_q);
      push_res.num    = wb_num;
      push_res.last   = s1_last_q;
      push_res.status = STAT_OK;
    end else begin
      push_res.dim    = '0;
      push_res.num    = '0;
      push_res.last   = 1'b1;
      push_res.status = STAT_OVF;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      first_q   <= 1'b1;
      xor_q     <= 1'b0;
      d_q       <= '0;
      sw_q      <= '0;
      s1_v_q    <= 1'b0;
      sw_wb_v_q <= 1'b0;
      ln_v_q    <= '0;
      out_wp_q  <= '0;
      out_rp_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      first_q   <= first_d;
      xor_q     <= xor_d;
      d_q       <= d_d;
      sw_q      <= sw_d;
      s1_v_q    <= run_issue;
      sw_wb_v_q <= sw_issue;
      if (ln_we) begin
        ln_v_q[ln_waddr] <= 1'b1;
      end
      if (out_push) begin
        out_wp_q <= (out_wp_q == OA_W'(OUT_DEPTH - 1)) ? '0 : out_wp_q + OA_W'(1);
      end
      if (out_pop) begin
        out_rp_q <= (out_rp_q == OA_W'(OUT_DEPTH - 1)) ? '0 : out_rp_q + OA_W'(1);
      end
      case ({out_push, out_pop})
        2'b10:   out_cnt_q <= out_cnt_q + OC_W'(1);
        2'b01:   out_cnt_q <= out_cnt_q - OC_W'(1);
        default: out_cnt_q <= out_cnt_q;
      endcase
    end
  end

  // Advance the direction address, track the read stages and write the result buffer
  always_ff @(posedge clk_i) begin
    dir_addr_q <= dir_addr_d;
    if (run_issue) begin
      s1_dim_q  <= d_q;
      s1_last_q <= run_last;
      s1_xor_q  <= xor_q;
      lnv_rd_q  <= ln_v_q[d_q];
    end
    if (sw_issue) begin
      sw_wb_idx_q <= sw_q;
    end
    if (out_push) begin
      out_mem[out_wp_q] <= push_res;
    end
  end

  // Direction store
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= cmd_i.value;
    end
    if (run_issue) begin
      dir_rd_q <= dir_mem[dir_addr_q];
    end
  end

  // Offset store
  always_ff @(posedge clk_i) begin
    if (ofs_we) begin
      ofs_mem[LN_AW'(cmd_i.dim)] <= cmd_i.value;
    end
    if (sw_issue) begin
      ofs_rd_q <= ofs_mem[sw_q];
    end
  end

  // Last numerator store
  always_ff @(posedge clk_i) begin
    if (ln_we) begin
      ln_mem[ln_waddr] <= ln_wdata;
    end
    if (run_issue) begin
      ln_rd_q <= ln_mem[d_q];
    end
  end

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_push && !out_pop && (out_cnt_q == OC_W'(OUT_DEPTH))))
    else $error("result buffer overflow");

  a_wb_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_wb && sw_wb_v_q))
    else $error("point and restart write back collide");

  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CALC && first_q) |=> (!first_q && cnt_q == '0))
    else $error("first point did not clear the pending flag");

  a_err_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ERR) |-> $stable(cnt_q))
    else $error("call counter moved on a too-many-calls result");

endmodule

`default_nettype wire

### rtl/sobol_gray_code_generator.sv
// Top level of the Sobol Gray-code point generator: config registers and wiring.
`default_nettype none

// Generates Sobol points by the Gray-code step, one coordinate per result
// transaction, last set on the final dimension. The front end takes one item
// per cycle while the two-entry command queue has room; the back end runs them
// in order. A load is written into its store as it is popped. A restart copies
// every offset into the numerator store, one entry a cycle. A next item is
// popped, its column is found, then its dimensions are read one per cycle while
// the result buffer has room, set by the single read port of the numerator and
// direction memories; a too-many-calls result is pushed once the buffer has
// room. A two-entry result buffer lets the back end keep going while results
// wait. Write configuration only while the block is idle.
module sobol_gray_code_generator #(
  parameter int unsigned MAX_DIMS = 40,
  parameter int unsigned MAX_BITS = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic [sgc_pkg::DIM_W-1:0]       dim_index_i,
  input  logic [sgc_pkg::BIT_W-1:0]       bit_index_i,
  input  logic [sgc_pkg::VAL_W-1:0]       load_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sgc_pkg::DIM_W-1:0]       out_dim_o,
  output logic [sgc_pkg::VAL_W-1:0]       numerator_o,
  output logic                            last_o,
  output logic                            status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sgc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sgc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sgc_pkg::*;

  cfg_t    cfg_q;
  logic    push;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    pop;
  q_stat_t q_stat;
  res_t    res;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dims <= DIM_W'(1);
      cfg_q.cols <= COL_W'(30);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DIMS: cfg_q.dims <= cfg_data_i[DIM_W-1:0];
        CFG_COLS: cfg_q.cols <= cfg_data_i[COL_W-1:0];
        default:  cfg_q      <= cfg_q;
      endcase
    end
  end

  sgc_front #(
    .MAX_DIMS (MAX_DIMS),
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .dim_index_i  (dim_index_i),
    .bit_index_i  (bit_index_i),
    .load_value_i (load_value_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  sgc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  sgc_back #(
    .MAX_DIMS (MAX_DIMS),
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_dim_o   = res.dim;
  assign numerator_o = res.num;
  assign last_o      = res.last;
  assign status_o    = res.status;

endmodule

`default_nettype wire
